@@ hw/rtl/bezier_easing_y_from_x_top_macros.svh @@
// assertion macros for the bezier easing block
`ifndef BEZIER_EASING_Y_FROM_X_TOP_MACROS_SVH
`define BEZIER_EASING_Y_FROM_X_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication on i_clk, off during reset
`define BEZ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bezier easing check failed");
// next-cycle implication on i_clk, off during reset
`define BEZ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bezier easing check failed");
`else
`define BEZ_ASSERT_IMP(lbl, ante, cons)
`define BEZ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/bez_pkg.sv @@
// types, constants and microcode tables for the bezier easing block
package bez_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = 17;
    localparam int ITER_W    = 6;
    localparam int VW        = FRAC_BITS + 16;
    localparam int PW        = 2 * VW;
    localparam int STEP_W    = 3;

    localparam int ONE_I = 1 << FRAC_BITS;
    localparam int EPS_I = (ONE_I * 5 + 5000) / 10000;
    localparam int FIELD_MAX_I = (1 << FIELD_W) - 1;
    localparam int SAT_HI_I = (ONE_I > FIELD_MAX_I) ? FIELD_MAX_I : ONE_I;

    localparam logic signed [VW-1:0] ONE_Q    = VW'(ONE_I);
    localparam logic signed [VW-1:0] EPS_Q    = VW'(EPS_I);
    localparam logic signed [VW-1:0] T_LIMIT  = VW'(4 * ONE_I);
    localparam logic signed [VW-1:0] SAT_HI_Q = VW'(SAT_HI_I);
    localparam logic [FIELD_W-1:0]   SAT_HI   = FIELD_W'(SAT_HI_I);
    localparam logic signed [PW-1:0] HALF_P   = PW'(ONE_I / 2);

    localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(12);

    // apb register map
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int REG_LSB   = 2;
    localparam logic [ADDR_W-REG_LSB-1:0] REG_MAX_ITER = '0;

    localparam logic [STEP_W-1:0] ITER_LAST = STEP_W'(5);
    localparam logic [STEP_W-1:0] EVAL_LAST = STEP_W'(7);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ITER,
        S_CHECK,
        S_EVAL,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_T2,
        OP_M2,
        OP_T3,
        OP_M1,
        OP_M0,
        OP_YT2,
        OP_YW,
        OP_YT3,
        OP_YU,
        OP_YZ,
        OP_YV,
        OP_YQ
    } t_op;

    // one refinement step: t^2, k2*t, t^3, k1*t^2, k0*t^3, drain
    function automatic t_op iter_op(input logic [STEP_W-1:0] s);
        t_op op;
        unique case (s)
            3'd0: op = OP_T2;
            3'd1: op = OP_M2;
            3'd2: op = OP_T3;
            3'd3: op = OP_M1;
            3'd4: op = OP_M0;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    // final evaluation of y from t and r = 1 - t
    function automatic t_op eval_op(input logic [STEP_W-1:0] s);
        t_op op;
        unique case (s)
            3'd0: op = OP_YT2;
            3'd1: op = OP_YW;
            3'd2: op = OP_YT3;
            3'd3: op = OP_YU;
            3'd4: op = OP_YZ;
            3'd5: op = OP_YV;
            3'd6: op = OP_YQ;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

@@ hw/rtl/bezier_easing_y_from_x_top.sv @@
// Cubic bezier easing: y on the curve (0,0)-P1-P2-(1,1) at progress x.
// Input channel i_valid/o_ready carries one item: progress_x and the two
// control points, all unsigned Q1.16. Output channel o_valid/i_ready carries
// eased_y (saturated to 0..1.0) and the converged flag.
// max_iterations sits at APB byte address 0 (reset 12); write it only while idle.
// All products go through one signed multiplier followed by a rounding stage;
// the sequencer issues at most one product per cycle and writes the rounded value back
// the next cycle, so a dependent product is issued only after that write-back.
// Each refinement step issues five products, then a drain and the residual check;
// after the steps comes the final evaluation, and the final state loads the output
// register. The identity curve skips straight to the final state.
// o_ready is high only while no item is in work; one item is processed at a time.
// The result waits in an output register: a stalled receiver holds it, and a new
// item may be accepted meanwhile, its result waiting in the final state until
// the register frees up.
// Reset returns to idle, drops o_valid and loads max_iterations with 12.
`include "bezier_easing_y_from_x_top_macros.svh"

module bezier_easing_y_from_x_top
    import bez_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [FIELD_W-1:0]   i_progress_x,
    input  logic [FIELD_W-1:0]   i_ctrl1_x,
    input  logic [FIELD_W-1:0]   i_ctrl1_y,
    input  logic [FIELD_W-1:0]   i_ctrl2_x,
    input  logic [FIELD_W-1:0]   i_ctrl2_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [FIELD_W-1:0]   o_eased_y,
    output logic                 o_converged,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    t_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [ITER_W-1:0] r_max_iter, n_max_iter;
    t_op r_wb, n_wb;
    logic r_ovalid, n_ovalid;

    logic signed [VW-1:0] r_t, n_t;
    logic signed [VW-1:0] r_r, n_r;
    logic signed [VW-1:0] r_t2, n_t2;
    logic signed [VW-1:0] r_t3, n_t3;
    logic signed [VW-1:0] r_w, n_w;
    logic signed [VW-1:0] r_acc, n_acc;
    logic signed [VW-1:0] r_x, n_x;
    logic signed [VW-1:0] r_k0, n_k0;
    logic signed [VW-1:0] r_k1, n_k1;
    logic signed [VW-1:0] r_k2, n_k2;
    logic signed [VW-1:0] r_ay, n_ay;
    logic signed [VW-1:0] r_by, n_by;
    logic r_conv, n_conv;
    logic [FIELD_W-1:0] r_y_out, n_y_out;
    logic r_conv_out, n_conv_out;

    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] rnd_sum;
    logic signed [VW-1:0] rnd;
    logic signed [VW-1:0] rnd3;
    logic signed [VW-1:0] mul_a, mul_b;
    t_op cur_op;

    logic signed [VW-1:0] x_v, ax_v, ay_v, bx_v, by_v;
    logic signed [VW-1:0] f_adj, half_f, t_sub, t_upd;
    logic signed [VW-1:0] acc_add;
    logic in_tol, last_iter, wr_en, out_free;
    logic [FIELD_W-1:0] y_sat;

    assign x_v  = VW'(i_progress_x);
    assign ax_v = VW'(i_ctrl1_x);
    assign ay_v = VW'(i_ctrl1_y);
    assign bx_v = VW'(i_ctrl2_x);
    assign by_v = VW'(i_ctrl2_y);

    // apb register
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    always_comb begin
        prdata = '0;
        if (paddr[ADDR_W-1:REG_LSB] == REG_MAX_ITER) begin
            prdata = DATA_W'(r_max_iter);
        end
    end

    always_comb begin
        cur_op = OP_NONE;
        if (r_state == S_ITER) begin
            cur_op = iter_op(r_step);
        end else if (r_state == S_EVAL) begin
            cur_op = eval_op(r_step);
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        unique case (cur_op)
            OP_T2, OP_YT2: begin mul_a = r_t;  mul_b = r_t;  end
            OP_M2:         begin mul_a = r_k2; mul_b = r_t;  end
            OP_T3, OP_YT3: begin mul_a = r_t2; mul_b = r_t;  end
            OP_M1:         begin mul_a = r_k1; mul_b = r_t2; end
            OP_M0:         begin mul_a = r_k0; mul_b = r_t3; end
            OP_YW:         begin mul_a = r_r;  mul_b = r_r;  end
            OP_YU:         begin mul_a = r_t2; mul_b = r_r;  end
            OP_YZ:         begin mul_a = r_t;  mul_b = r_w;  end
            OP_YV:         begin mul_a = r_t3; mul_b = r_by; end
            OP_YQ:         begin mul_a = r_w;  mul_b = r_ay; end
            default:       begin mul_a = '0;   mul_b = '0;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // round half away from zero: add half, less one when negative, then shift
    assign rnd_sum = r_prod + HALF_P - PW'(r_prod[PW-1]);
    assign rnd     = rnd_sum[FRAC_BITS +: VW];
    assign rnd3    = (rnd <<< 1) + rnd;

    // residual check and newton-like update of t
    assign in_tol    = (r_acc <= EPS_Q) && (r_acc >= -EPS_Q);
    assign f_adj     = r_acc + {{(VW-1){1'b0}}, r_acc[VW-1]};
    assign half_f    = f_adj >>> 1;
    assign t_sub     = r_t - half_f;
    assign last_iter = ({1'b0, r_iter} + (ITER_W+1)'(1)) == {1'b0, r_max_iter};

    always_comb begin
        if (t_sub > T_LIMIT) begin
            t_upd = T_LIMIT;
        end else if (t_sub < -T_LIMIT) begin
            t_upd = -T_LIMIT;
        end else begin
            t_upd = t_sub;
        end
    end

    always_comb begin
        if (r_acc < 0) begin
            y_sat = '0;
        end else if (r_acc > SAT_HI_Q) begin
            y_sat = SAT_HI;
        end else begin
            y_sat = r_acc[FIELD_W-1:0];
        end
    end

    assign out_free = !r_ovalid || i_ready;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_iter     = r_iter;
        n_max_iter = r_max_iter;
        n_wb       = cur_op;
        n_ovalid   = r_ovalid;
        n_t        = r_t;
        n_r        = r_r;
        n_t2       = r_t2;
        n_t3       = r_t3;
        n_w        = r_w;
        n_acc      = r_acc;
        n_x        = r_x;
        n_k0       = r_k0;
        n_k1       = r_k1;
        n_k2       = r_k2;
        n_ay       = r_ay;
        n_by       = r_by;
        n_conv     = r_conv;
        n_y_out    = r_y_out;
        n_conv_out = r_conv_out;
        o_ready    = (r_state == S_IDLE);

        if (wr_en && (paddr[ADDR_W-1:REG_LSB] == REG_MAX_ITER)) begin
            n_max_iter = pwdata[ITER_W-1:0];
        end

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        // write back the rounded product issued last cycle
        acc_add = '0;
        unique case (r_wb)
            OP_T2, OP_YT2:               n_t2 = rnd;
            OP_T3, OP_YU:                n_t3 = rnd;
            OP_YW, OP_YZ:                n_w  = rnd;
            OP_M0, OP_M1, OP_M2, OP_YT3: acc_add = rnd;
            OP_YV, OP_YQ:                acc_add = rnd3;
            default:                     acc_add = '0;
        endcase
        n_acc = r_acc + acc_add;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_x    = x_v;
                    n_ay   = ay_v;
                    n_by   = by_v;
                    n_k0   = ONE_Q + VW'(3) * ax_v - VW'(3) * bx_v;
                    n_k1   = VW'(3) * bx_v - VW'(6) * ax_v;
                    n_k2   = VW'(3) * ax_v;
                    n_t    = x_v;
                    n_r    = ONE_Q - x_v;
                    n_iter = '0;
                    n_step = '0;
                    n_conv = 1'b0;
                    if ((i_ctrl1_x == i_ctrl1_y) && (i_ctrl2_x == i_ctrl2_y)) begin
                        // identity curve: y is x
                        n_acc   = x_v;
                        n_conv  = 1'b1;
                        n_state = S_FIN;
                    end else if (r_max_iter == '0) begin
                        n_acc   = '0;
                        n_state = S_EVAL;
                    end else begin
                        n_acc   = -x_v;
                        n_state = S_ITER;
                    end
                end
            end
            S_ITER: begin
                if (r_step == ITER_LAST) begin
                    n_state = S_CHECK;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_CHECK: begin
                n_step = '0;
                if (in_tol) begin
                    n_conv  = 1'b1;
                    n_r     = ONE_Q - r_t;
                    n_acc   = '0;
                    n_state = S_EVAL;
                end else begin
                    n_t = t_upd;
                    if (last_iter) begin
                        n_r     = ONE_Q - t_upd;
                        n_acc   = '0;
                        n_state = S_EVAL;
                    end else begin
                        n_acc   = -r_x;
                        n_iter  = r_iter + ITER_W'(1);
                        n_state = S_ITER;
                    end
                end
            end
            S_EVAL: begin
                if (r_step == EVAL_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_y_out    = y_sat;
                    n_conv_out = r_conv;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_iter     <= '0;
            r_max_iter <= MAX_ITER_RESET;
            r_wb       <= OP_NONE;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_iter     <= n_iter;
            r_max_iter <= n_max_iter;
            r_wb       <= n_wb;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t        <= n_t;
        r_r        <= n_r;
        r_t2       <= n_t2;
        r_t3       <= n_t3;
        r_w        <= n_w;
        r_acc      <= n_acc;
        r_x        <= n_x;
        r_k0       <= n_k0;
        r_k1       <= n_k1;
        r_k2       <= n_k2;
        r_ay       <= n_ay;
        r_by       <= n_by;
        r_conv     <= n_conv;
        r_y_out    <= n_y_out;
        r_conv_out <= n_conv_out;
    end

    assign o_valid     = r_ovalid;
    assign o_eased_y   = r_y_out;
    assign o_converged = r_conv_out;

    `BEZ_ASSERT_NEXT(a_accept_busy, i_valid && o_ready, r_state != S_IDLE)
    `BEZ_ASSERT_IMP(a_t_in_range, r_state == S_CHECK, (r_t <= T_LIMIT) && (r_t >= -T_LIMIT))
    `BEZ_ASSERT_IMP(a_step_bound, r_state == S_ITER, r_step <= ITER_LAST)
    `BEZ_ASSERT_NEXT(a_fin_loads, (r_state == S_FIN) && !r_ovalid, r_ovalid)

endmodule

@@ sim/bezier_easing_y_from_x_top_tb.sv @@
// self-checking testbench for the bezier easing block: random and directed items, apb config
module bezier_easing_y_from_x_top_tb
    import bez_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [FIELD_W-1:0] progress_x;
        logic [FIELD_W-1:0] ctrl1_x;
        logic [FIELD_W-1:0] ctrl1_y;
        logic [FIELD_W-1:0] ctrl2_x;
        logic [FIELD_W-1:0] ctrl2_y;
    } t_ease_req;

    typedef struct {
        logic [FIELD_W-1:0] eased_y;
        logic               converged;
    } t_ease_res;

    localparam longint Q_ONE   = longint'(1) << FRAC_BITS;
    localparam longint Q_EPS   = (Q_ONE * 5 + 5000) / 10000;
    localparam longint T_CLAMP = 4 * Q_ONE;
    localparam longint FIELD_TOP = (longint'(1) << FIELD_W) - 1;
    localparam longint Y_CEIL  = (Q_ONE > FIELD_TOP) ? FIELD_TOP : Q_ONE;
    localparam logic [ADDR_W-1:0] ITER_ADDR = ADDR_W'(REG_MAX_ITER) << REG_LSB;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES = 8;
    localparam int ITER_RANDOM = -1;

    // per phase: iteration limit, item count, sender and receiver idle percent
    int ph_iters [PHASES] = '{0, 63, 1, 12, 5, ITER_RANDOM, 8, 12};
    int ph_items [PHASES] = '{250, 60, 250, 300, 250, 150, 250, 200};
    int ph_send  [PHASES] = '{0, 48, 0, 19, 0, 48, 0, 19};
    int ph_recv  [PHASES] = '{0, 0, 48, 19, 0, 0, 48, 19};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [FIELD_W-1:0] i_progress_x = '0;
    logic [FIELD_W-1:0] i_ctrl1_x = '0;
    logic [FIELD_W-1:0] i_ctrl1_y = '0;
    logic [FIELD_W-1:0] i_ctrl2_x = '0;
    logic [FIELD_W-1:0] i_ctrl2_y = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [FIELD_W-1:0] o_eased_y;
    logic               o_converged;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    t_ease_req          req_queue[$];
    t_ease_res          ease_expected[$];
    logic [ITER_W-1:0]  iter_limit = MAX_ITER_RESET;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 err_count = 0;
    int                 idle_cycles = 0;
    t_ease_req          drv_item;
    t_ease_res          mon_expect;

    bezier_easing_y_from_x_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_progress_x (i_progress_x),
        .i_ctrl1_x    (i_ctrl1_x),
        .i_ctrl1_y    (i_ctrl1_y),
        .i_ctrl2_x    (i_ctrl2_x),
        .i_ctrl2_y    (i_ctrl2_y),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_eased_y    (o_eased_y),
        .o_converged  (o_converged),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // fixed-point product, rounded half away from zero
    function automatic longint q_mul(longint a, longint b);
        longint p;
        longint unsigned mag;
        p = a * b;
        mag = (p < 0) ? longint'(-p) : longint'(p);
        mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return (p < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [FIELD_W-1:0] clamp_y(longint v);
        if (v < 0)
            v = 0;
        if (v > Y_CEIL)
            v = Y_CEIL;
        return FIELD_W'(v);
    endfunction

    // solve x(t) = progress by damped refinement, then evaluate y(t)
    function automatic t_ease_res eval_bezier_y(t_ease_req rq, logic [ITER_W-1:0] n_iter);
        longint x, ax, ay, bx, by, k0, k1, k2, t, r, t2, t3, f, y;
        t_ease_res res;
        x  = longint'(rq.progress_x);
        ax = longint'(rq.ctrl1_x);
        ay = longint'(rq.ctrl1_y);
        bx = longint'(rq.ctrl2_x);
        by = longint'(rq.ctrl2_y);
        res.converged = 1'b0;
        if (ax == ay && bx == by) begin
            res.eased_y = clamp_y(x);
            res.converged = 1'b1;
        end else begin
            k0 = Q_ONE + 3 * ax - 3 * bx;
            k1 = 3 * bx - 6 * ax;
            k2 = 3 * ax;
            t = x;
            for (int i = 0; i < int'(n_iter) && !res.converged; i++) begin
                t2 = q_mul(t, t);
                t3 = q_mul(t2, t);
                f = q_mul(k0, t3) + q_mul(k1, t2) + q_mul(k2, t) - x;
                if (f <= Q_EPS && f >= -Q_EPS) begin
                    res.converged = 1'b1;
                end else begin
                    // halving truncates toward zero
                    t = t - ((f < 0) ? -((-f) >>> 1) : (f >>> 1));
                    if (t > T_CLAMP)
                        t = T_CLAMP;
                    if (t < -T_CLAMP)
                        t = -T_CLAMP;
                end
            end
            r = Q_ONE - t;
            t2 = q_mul(t, t);
            t3 = q_mul(t2, t);
            y = t3 + 3 * q_mul(q_mul(t2, r), by) + 3 * q_mul(q_mul(t, q_mul(r, r)), ay);
            res.eased_y = clamp_y(y);
        end
        return res;
    endfunction

    // mostly in 0..1 with the ends favored, sometimes anywhere in the field
    function automatic logic [FIELD_W-1:0] rand_coord();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return '0;
        else if (sel < 10)
            return FIELD_W'(Q_ONE);
        else if (sel < 17)
            return FIELD_W'($urandom_range(32'(FIELD_TOP)));
        else
            return FIELD_W'($urandom_range(32'(Q_ONE)));
    endfunction

    task automatic add_req(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] ax,
                           logic [FIELD_W-1:0] ay, logic [FIELD_W-1:0] bx,
                           logic [FIELD_W-1:0] by);
        t_ease_req rq;
        rq.progress_x = x;
        rq.ctrl1_x = ax;
        rq.ctrl1_y = ay;
        rq.ctrl2_x = bx;
        rq.ctrl2_y = by;
        req_queue = {req_queue, rq};
    endtask

    task automatic wait_drain();
        while (req_queue.size() != 0 || i_valid || ease_expected.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ITER_ADDR)
            iter_limit = data[ITER_W-1:0];
    endtask

    // driver: predicts on acceptance, then presents the next queued item or idles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                ease_expected = {ease_expected,
                                 eval_bezier_y('{i_progress_x, i_ctrl1_x, i_ctrl1_y,
                                                 i_ctrl2_x, i_ctrl2_y}, iter_limit)};
            if (!i_valid || o_ready) begin
                if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = req_queue.pop_front();
                    i_valid <= 1'b1;
                    i_progress_x <= drv_item.progress_x;
                    i_ctrl1_x <= drv_item.ctrl1_x;
                    i_ctrl1_y <= drv_item.ctrl1_y;
                    i_ctrl2_x <= drv_item.ctrl2_x;
                    i_ctrl2_y <= drv_item.ctrl2_y;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (ease_expected.size() == 0) begin
                    $error("unexpected result: eased_y %0d converged %0d",
                           o_eased_y, o_converged);
                    err_count++;
                end else begin
                    mon_expect = ease_expected.pop_front();
                    if (o_eased_y !== mon_expect.eased_y) begin
                        $error("eased_y mismatch: expected %0d, got %0d",
                               mon_expect.eased_y, o_eased_y);
                        err_count++;
                    end
                    if (o_converged !== mon_expect.converged) begin
                        $error("converged mismatch: expected %0d, got %0d",
                               mon_expect.converged, o_converged);
                        err_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [FIELD_W-1:0] ax, bx;
        int lim;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at the reset iteration limit
        add_req('0, '0, '0, '0, '0);
        add_req(17'd32768, 17'd1000, 17'd1000, 17'd65536, 17'd65536);
        add_req(17'd65536, 17'd40000, 17'd40000, 17'd9, 17'd9);
        add_req(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        add_req(17'd0, 17'd16384, 17'd6554, 17'd16384, 17'd65536);
        add_req(17'd32768, 17'd16384, 17'd6554, 17'd16384, 17'd65536);
        add_req(17'd65536, 17'd16384, 17'd6554, 17'd16384, 17'd65536);
        add_req(17'd13107, 17'd27525, 17'd0, 17'd38011, 17'd65536);
        add_req(17'd52429, 17'd27525, 17'd0, 17'd38011, 17'd65536);
        add_req(17'd20000, 17'd20000, 17'd20000, 17'd30000, 17'd31000);
        add_req(17'd20000, 17'd20000, 17'd21000, 17'd30000, 17'd30000);
        // overshoot past 1.0 and runaway refinement
        add_req(17'd32768, 17'd0, 17'h1FFFF, 17'd65536, 17'h1FFFF);
        add_req(17'h1FFFF, 17'h1FFFF, 17'd0, 17'd0, 17'h1FFFF);
        add_req(17'd65536, 17'd0, 17'h1FFFF, 17'h1FFFF, 17'd0);
        add_req(17'h1FFFF, 17'd0, 17'd65536, 17'd65536, 17'd0);
        add_req(17'd1, 17'h10000, 17'h0FFFF, 17'h0AAAA, 17'h15555);
        add_req(17'd65535, 17'h15555, 17'h0AAAA, 17'h1FFFF, 17'd1);
        wait_drain();

        for (int p = 0; p < PHASES; p++) begin
            lim = (ph_iters[p] == ITER_RANDOM) ? $urandom_range(63) : ph_iters[p];
            apb_write(ITER_ADDR, DATA_W'(lim));
            send_idle_pct = ph_send[p];
            recv_idle_pct = ph_recv[p];
            for (int n = 0; n < ph_items[p]; n++) begin
                ax = rand_coord();
                bx = rand_coord();
                // some curves take the identity shortcut
                if ($urandom_range(99) < 12)
                    add_req(rand_coord(), ax, ax, bx, bx);
                else
                    add_req(rand_coord(), ax, rand_coord(), bx, rand_coord());
            end
            wait_drain();
        end

        repeat (500) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
